// ----- hw/rtl/lrc_pkg.sv -----
// Shared constants and types for the LRU replacement cache core.
// Used by lrc_ctrl, lrc_datapath and lru_replacement_cache_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

    // Built entry count and derived widths
    localparam int ENTRIES = 16;
    localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W   = RANK_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 32;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Command field codes
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the input transaction
        logic match;   // run the tag compare and register its outcome
        logic commit;  // update the entries and load the result register
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- hw/rtl/lrc_ctrl.sv -----
// Controller state machine for the LRU replacement cache core.
// Depends on lrc_pkg (t_dp_cmd); drives the datapath commands and both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module lrc_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output lrc_pkg::t_dp_cmd o_dp_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_WRITE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Sequence one transaction: capture, compare, write back
    always_comb begin
        n_state         = r_state;
        o_dp_cmd.load   = 1'b0;
        o_dp_cmd.match  = 1'b0;
        o_dp_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = ST_MATCH;
                end
            end
            ST_MATCH: begin
                o_dp_cmd.match = 1'b1;
                n_state        = ST_WRITE;
            end
            ST_WRITE: begin
                // hold until the result register is free
                if (w_out_free) begin
                    o_dp_cmd.commit = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Track the result register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_dp_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lrc_datapath.sv -----
// Datapath of the LRU replacement cache core: keys, recency ranks, counters, result.
// Depends on lrc_pkg; steered by lrc_ctrl through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module lrc_datapath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lrc_pkg::t_dp_cmd                   i_dp_cmd,
    input  wire                                i_cfg_we,
    input  wire        [lrc_pkg::CAP_W-1:0]    i_cfg_data,
    input  wire                                i_cmd,
    input  wire signed [lrc_pkg::KEY_W-1:0]    i_request_key,
    output logic                               o_hit,
    output logic                               o_evicted_valid,
    output logic signed [lrc_pkg::KEY_W-1:0]   o_evicted_key,
    output logic       [lrc_pkg::CNT_W-1:0]    o_miss_count
);

    localparam int N = lrc_pkg::ENTRIES;

    // Configuration and captured transaction
    logic [lrc_pkg::CAP_W-1:0]        r_capacity;
    logic                             r_cmd;
    logic [lrc_pkg::KEY_W-1:0]        r_key;

    // Cache state
    logic [lrc_pkg::KEY_W-1:0]        r_keys [N];
    logic [N-1:0]                     r_valid, n_valid;
    logic [lrc_pkg::RANK_W-1:0]       r_rank [N];
    logic [lrc_pkg::RANK_W-1:0]       n_rank [N];
    logic [lrc_pkg::OCC_W-1:0]        r_occ;
    logic [lrc_pkg::CNT_W-1:0]        r_miss;

    // Compare stage results
    logic                             r_hit;
    logic [N-1:0]                     r_hit_oh;
    logic [lrc_pkg::RANK_W-1:0]       r_hit_rank;
    logic                             r_evict;
    logic [N-1:0]                     r_victim_oh;
    logic [lrc_pkg::KEY_W-1:0]        r_victim_key;

    // Compare stage logic
    logic [N-1:0]                     w_hit_oh;
    logic [lrc_pkg::RANK_W-1:0]       w_hit_rank;
    logic [N-1:0]                     w_victim_oh;
    logic [lrc_pkg::KEY_W-1:0]        w_victim_key;
    logic [lrc_pkg::CMP_W-1:0]        w_eff_cap;
    logic [lrc_pkg::CMP_W-1:0]        w_occ_ext;
    logic [lrc_pkg::OCC_W-1:0]        w_lru_rank;
    logic                             w_evict;

    // Write stage logic
    logic [N-1:0]                     w_free;
    logic [lrc_pkg::IDX_W-1:0]        w_free_idx;
    logic [N-1:0]                     w_after_evict;
    logic [lrc_pkg::OCC_W-1:0]        n_occ;
    logic [lrc_pkg::CNT_W-1:0]        n_miss;

    // Clamp the capacity into one to the built entry count
    always_comb begin
        w_eff_cap = lrc_pkg::CMP_W'(r_capacity);
        if (r_capacity == '0) begin
            w_eff_cap = lrc_pkg::CMP_W'(1);
        end else if (w_eff_cap > lrc_pkg::CMP_W'(N)) begin
            w_eff_cap = lrc_pkg::CMP_W'(N);
        end
    end

    assign w_occ_ext  = lrc_pkg::CMP_W'(r_occ);
    assign w_lru_rank = r_occ - lrc_pkg::OCC_W'(1);
    assign w_evict    = (w_occ_ext >= w_eff_cap) && (r_occ != '0);

    // Compare all entries; the least recent valid entry has rank occupancy-1
    always_comb begin
        w_hit_rank   = '0;
        w_victim_key = '0;
        for (int i = 0; i < N; i++) begin
            w_hit_oh[i]    = r_valid[i] && (r_keys[i] == r_key);
            w_victim_oh[i] = r_valid[i] &&
                             (lrc_pkg::OCC_W'(r_rank[i]) == w_lru_rank);
            w_hit_rank     = w_hit_rank | (r_rank[i] & {lrc_pkg::RANK_W{w_hit_oh[i]}});
            w_victim_key   = w_victim_key |
                             (r_keys[i] & {lrc_pkg::KEY_W{w_victim_oh[i]}});
        end
    end

    // Find the lowest free entry once the victim is released
    always_comb begin
        w_after_evict = r_valid & ~(r_victim_oh & {N{r_evict}});
        w_free        = ~w_after_evict;
        w_free_idx    = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_free_idx = lrc_pkg::IDX_W'(i);
            end
        end
    end

    // Next entry state for a committed transaction
    always_comb begin
        n_valid = r_valid;
        n_occ   = r_occ;
        n_miss  = r_miss;
        for (int i = 0; i < N; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (r_cmd == lrc_pkg::CMD_FLUSH) begin
            n_valid = '0;
            n_occ   = '0;
            n_miss  = '0;
            for (int i = 0; i < N; i++) begin
                n_rank[i] = '0;
            end
        end else if (r_hit) begin
            // promote the hit entry, age those more recent than it
            for (int i = 0; i < N; i++) begin
                if (r_hit_oh[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                    n_rank[i] = r_rank[i] + lrc_pkg::RANK_W'(1);
                end
            end
        end else begin
            // drop the victim, age survivors, insert as most recent
            if (r_miss != '1) begin
                n_miss = r_miss + lrc_pkg::CNT_W'(1);
            end
            n_occ = r_occ - lrc_pkg::OCC_W'(r_evict) + lrc_pkg::OCC_W'(1);
            for (int i = 0; i < N; i++) begin
                if (lrc_pkg::IDX_W'(i) == w_free_idx) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (w_after_evict[i]) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = r_rank[i] + lrc_pkg::RANK_W'(1);
                end else begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end
            end
        end
    end

    // Control state: capacity, valid bits, ranks, occupancy, counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lrc_pkg::CAP_RESET;
            r_valid    <= '0;
            r_occ      <= '0;
            r_miss     <= '0;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_dp_cmd.commit) begin
                r_valid <= n_valid;
                r_occ   <= n_occ;
                r_miss  <= n_miss;
                for (int i = 0; i < N; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    // Payload: captured transaction, compare results, stored keys, result
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd <= i_cmd;
            r_key <= i_request_key;
        end
        if (i_dp_cmd.match) begin
            r_hit        <= |w_hit_oh;
            r_hit_oh     <= w_hit_oh;
            r_hit_rank   <= w_hit_rank;
            r_evict      <= w_evict;
            r_victim_oh  <= w_victim_oh;
            r_victim_key <= w_victim_key;
        end
        if (i_dp_cmd.commit) begin
            if ((r_cmd == lrc_pkg::CMD_ACCESS) && !r_hit) begin
                r_keys[w_free_idx] <= r_key;
            end
            if (r_cmd == lrc_pkg::CMD_FLUSH) begin
                o_hit           <= 1'b0;
                o_evicted_valid <= 1'b0;
                o_evicted_key   <= '0;
            end else begin
                o_hit           <= r_hit;
                o_evicted_valid <= !r_hit && r_evict;
                o_evicted_key   <= (!r_hit && r_evict) ? r_victim_key : '0;
            end
            o_miss_count <= n_miss;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lru_replacement_cache_core.sv -----
// Top level of the fully associative LRU replacement cache core.
// Depends on lrc_pkg, lrc_ctrl and lrc_datapath.
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------------
//  request  | i_in_valid / o_in_ready   | i_cmd, i_request_key
//  result   | o_out_valid / i_out_ready | o_hit, o_evicted_valid, o_evicted_key,
//           |                           | o_miss_count
//  config   | i_cfg_we (no wait)        | i_cfg_data (capacity)
//
// Each transaction passes through capture, parallel tag and rank compare,
// then write-back of entries, ranks and counter. The compare-then-update
// sequence in the controller takes no new request until the last one is written back.
// The result register frees the request side: a new request is taken while a
// result waits; a commit waits only while the result register is still full.
// Synchronous active-low reset empties the cache, clears the counter and sets
// capacity to 16; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_replacement_cache_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire        [lrc_pkg::CAP_W-1:0]    i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire                                i_cmd,
    input  wire signed [lrc_pkg::KEY_W-1:0]    i_request_key,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_hit,
    output logic                               o_evicted_valid,
    output logic signed [lrc_pkg::KEY_W-1:0]   o_evicted_key,
    output logic       [lrc_pkg::CNT_W-1:0]    o_miss_count
);

    lrc_pkg::t_dp_cmd w_dp_cmd;

    // Sequence transactions and handshakes
    lrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dp_cmd    (w_dp_cmd)
    );

    // Hold the entries and compute results
    lrc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (w_dp_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_request_key   (i_request_key),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key),
        .o_miss_count    (o_miss_count)
    );

endmodule

`default_nettype wire

// ----- tb/tb_lru_replacement_cache_core.sv -----
// Self-checking testbench for lru_replacement_cache_core: directed and random accesses,
// flushes and capacity settings, checked against an LRU cache predictor.
// Depends on lrc_pkg and the lru_replacement_cache_core RTL.
`timescale 1ns / 1ps

module tb_lru_replacement_cache_core;

    localparam int ENTRIES     = lrc_pkg::ENTRIES;
    localparam int KEY_W       = lrc_pkg::KEY_W;
    localparam int CNT_W       = lrc_pkg::CNT_W;
    localparam int CAP_W       = lrc_pkg::CAP_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_MAX    = 24;

    typedef struct packed {
        logic              hit;
        logic              evicted_valid;
        logic [KEY_W-1:0]  evicted_key;
        logic [CNT_W-1:0]  miss_count;
    } t_cache_result;

    // DUT connections
    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [CAP_W-1:0]   cfg_data;
    logic               in_valid;
    logic               o_in_ready;
    logic               in_cmd;
    logic [KEY_W-1:0]   in_key;
    logic               o_out_valid;
    logic               out_ready;
    logic               o_hit;
    logic               o_evicted_valid;
    logic [KEY_W-1:0]   o_evicted_key;
    logic [CNT_W-1:0]   o_miss_count;

    // Cache predictor state
    logic [KEY_W-1:0]   lru_keys  [ENTRIES];
    logic               lru_valid [ENTRIES];
    int unsigned        lru_rank  [ENTRIES];
    int unsigned        lru_occupancy;
    logic [CNT_W-1:0]   lru_misses;
    logic [CAP_W-1:0]   lru_capacity;

    t_cache_result      pending_results[$];
    t_cache_result      want_result;
    int                 error_count;
    int                 cycle_count;
    int                 idle_pct;
    int                 stall_pct;

    lru_replacement_cache_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (in_cmd),
        .i_request_key   (in_key),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key),
        .o_miss_count    (o_miss_count)
    );

    // Clock generation
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one transaction to the predictor and return the result it should produce
    function automatic t_cache_result lru_predict(input logic cmd, input logic [KEY_W-1:0] key);
        t_cache_result res;
        int            slot;
        int            victim;
        int unsigned   eff_cap;
        int unsigned   hit_rank;
        res    = '0;
        slot   = -1;
        victim = -1;
        if (cmd == lrc_pkg::CMD_FLUSH) begin
            for (int i = 0; i < ENTRIES; i++) begin
                lru_valid[i] = 1'b0;
                lru_rank[i]  = 0;
            end
            lru_occupancy = 0;
            lru_misses    = '0;
        end else begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && lru_valid[i] && lru_keys[i] == key)
                    slot = i;
            if (slot >= 0) begin
                // Hit: promote the entry, age everything that was more recent
                res.hit  = 1'b1;
                hit_rank = lru_rank[slot];
                for (int i = 0; i < ENTRIES; i++)
                    if (lru_valid[i] && lru_rank[i] < hit_rank)
                        lru_rank[i]++;
                lru_rank[slot] = 0;
            end else begin
                // Miss: count (saturating), evict the oldest when full, insert as newest
                if (lru_misses != '1)
                    lru_misses++;
                eff_cap = lru_capacity;
                if (eff_cap < 1)
                    eff_cap = 1;
                if (eff_cap > ENTRIES)
                    eff_cap = ENTRIES;
                if (lru_occupancy >= eff_cap && lru_occupancy > 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (lru_valid[i] && (victim < 0 || lru_rank[i] > lru_rank[victim]))
                            victim = i;
                    if (victim >= 0) begin
                        res.evicted_valid = 1'b1;
                        res.evicted_key   = lru_keys[victim];
                        lru_valid[victim] = 1'b0;
                        lru_rank[victim]  = 0;
                        lru_occupancy--;
                    end
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !lru_valid[i])
                        slot = i;
                if (slot >= 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (lru_valid[i])
                            lru_rank[i]++;
                    lru_keys[slot]  = key;
                    lru_valid[slot] = 1'b1;
                    lru_rank[slot]  = 0;
                    lru_occupancy++;
                end
            end
        end
        res.miss_count = lru_misses;
        return res;
    endfunction

    // Offer one request transaction, with random idle cycles ahead of it
    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_key   <= key;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(lru_predict(cmd, key));
    endtask

    // Hold off the request side until every outstanding result has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the capacity register while the core is idle
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        lru_capacity = value;
    endtask

    // Extreme key values, hits on them, and a flush that clears the miss count
    task automatic test_key_extremes();
        set_capacity(CAP_W'(16));
        send_item(lrc_pkg::CMD_ACCESS, 32'h8000_0000);
        send_item(lrc_pkg::CMD_ACCESS, 32'h7FFF_FFFF);
        send_item(lrc_pkg::CMD_ACCESS, 32'h0000_0000);
        send_item(lrc_pkg::CMD_ACCESS, 32'hFFFF_FFFF);
        send_item(lrc_pkg::CMD_ACCESS, 32'h5555_5555);
        send_item(lrc_pkg::CMD_ACCESS, 32'hAAAA_AAAA);
        send_item(lrc_pkg::CMD_ACCESS, 32'h8000_0000);
        send_item(lrc_pkg::CMD_ACCESS, 32'hFFFF_FFFF);
        send_item(lrc_pkg::CMD_FLUSH, 32'hFFFF_FFFF);
        send_item(lrc_pkg::CMD_ACCESS, 32'h7FFF_FFFF);
    endtask

    // Zero capacity behaves as a single entry
    task automatic test_capacity_zero();
        set_capacity(CAP_W'(0));
        send_item(lrc_pkg::CMD_ACCESS, 32'h1234_5678);
        send_item(lrc_pkg::CMD_ACCESS, 32'h8765_4321);
        send_item(lrc_pkg::CMD_ACCESS, 32'h8765_4321);
        send_item(lrc_pkg::CMD_ACCESS, 32'h1234_5678);
    endtask

    // Capacity lowered below occupancy: each miss evicts one entry, hits keep all
    task automatic test_capacity_shrink();
        set_capacity(CAP_W'(16));
        send_item(lrc_pkg::CMD_FLUSH, 32'h0);
        send_item(lrc_pkg::CMD_ACCESS, 32'h0000_0011);
        send_item(lrc_pkg::CMD_ACCESS, 32'h0000_0022);
        send_item(lrc_pkg::CMD_ACCESS, 32'h0000_0033);
        send_item(lrc_pkg::CMD_ACCESS, 32'h0000_0044);
        set_capacity(CAP_W'(2));
        send_item(lrc_pkg::CMD_ACCESS, 32'h0000_0055);
        send_item(lrc_pkg::CMD_ACCESS, 32'h0000_0022);
        send_item(lrc_pkg::CMD_ACCESS, 32'h0000_0066);
    endtask

    // Random traffic over a small key pool so hits and evictions are frequent
    task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int idle,
                                       input int stall, input int count);
        logic [KEY_W-1:0] key_pool [POOL_MAX];
        int               pool_n;
        logic             cmd;
        logic [KEY_W-1:0] key;
        set_capacity(cap);
        idle_pct  = idle;
        stall_pct = stall;
        pool_n    = $urandom_range(POOL_MAX, 2);
        for (int i = 0; i < POOL_MAX; i++)
            key_pool[i] = $urandom;
        for (int n = 0; n < count; n++) begin
            // Pause once mid-phase until the result side has fully drained
            if (n == count / 2)
                wait_for_results();
            cmd = ($urandom_range(99) < 2) ? lrc_pkg::CMD_FLUSH : lrc_pkg::CMD_ACCESS;
            if ($urandom_range(99) < 85)
                key = key_pool[$urandom_range(pool_n - 1)];
            else
                key = $urandom;
            send_item(cmd, key);
        end
        wait_for_results();
    endtask

    // Result side back-pressure
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result hit=%0b miss_count=%h", $time, o_hit,
                         o_miss_count);
                error_count++;
            end else begin
                want_result = pending_results.pop_front();
                if (o_hit !== want_result.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want_result.hit, o_hit);
                    error_count++;
                end
                if (o_evicted_valid !== want_result.evicted_valid) begin
                    $display("%0t: evicted_valid expected %0b actual %0b", $time,
                             want_result.evicted_valid, o_evicted_valid);
                    error_count++;
                end
                if (o_evicted_key !== want_result.evicted_key) begin
                    $display("%0t: evicted_key expected %h actual %h", $time,
                             want_result.evicted_key, o_evicted_key);
                    error_count++;
                end
                if (o_miss_count !== want_result.miss_count) begin
                    $display("%0t: miss_count expected %h actual %h", $time,
                             want_result.miss_count, o_miss_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lru_replacement_cache_core: mismatch");
            $finish;
        end
    end

    // Test sequence
    initial begin
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_cmd      = lrc_pkg::CMD_ACCESS;
        in_key      = '0;
        out_ready   = 1'b1;
        idle_pct    = 0;
        stall_pct   = 0;
        error_count = 0;
        cycle_count = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            lru_keys[i]  = '0;
            lru_valid[i] = 1'b0;
            lru_rank[i]  = 0;
        end
        lru_occupancy = 0;
        lru_misses    = '0;
        lru_capacity  = lrc_pkg::CAP_RESET;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_key_extremes();
        test_capacity_zero();
        test_capacity_shrink();
        test_random_traffic(CAP_W'(16), 0, 0, 128);
        test_random_traffic(CAP_W'(31), 75, 0, 128);
        test_random_traffic(CAP_W'(1), 0, 75, 128);
        test_random_traffic(CAP_W'(4), 11, 11, 128);
        test_random_traffic(CAP_W'(0), 0, 0, 128);
        test_random_traffic(CAP_W'(17), 75, 0, 128);
        test_random_traffic(CAP_W'(8), 0, 75, 128);
        test_random_traffic(CAP_W'(3), 11, 11, 128);

        // Let any stray result show up before the verdict
        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("lru_replacement_cache_core: match");
        end else begin
            $display("lru_replacement_cache_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lrc_pkg.sv
hw/rtl/lrc_ctrl.sv
hw/rtl/lrc_datapath.sv
hw/rtl/lru_replacement_cache_core.sv
tb/tb_lru_replacement_cache_core.sv
